// ----- design/rcfs_pkg.sv -----
package rcfs_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int IDX_W  = 5;
  localparam int KIND_W = 2;

  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h0F;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [KIND_W-1:0] KIND_FRAME     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VALUE     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic frame_done;
    logic frame_ok;
  } rcfs_win_stat_t;

endpackage

// ----- design/rcfs_window.sv -----
module rcfs_window #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    byte_valid,
  input  logic [rcfs_pkg::BYTE_W-1:0]             byte_in,
  input  logic [rcfs_pkg::BYTE_W-1:0]             sync_byte,
  output rcfs_pkg::rcfs_win_stat_t                stat,
  output logic [NUM_CHANNELS-1:0][rcfs_pkg::WORD_W-1:0] words
);
  import rcfs_pkg::*;

  localparam int FRAME_LEN = 2 * NUM_CHANNELS + 3;
  localparam int BODY_LEN  = FRAME_LEN - 2;
  localparam int FILL_W    = $clog2(FRAME_LEN);

  logic [BYTE_W-1:0]   win_r   [FRAME_LEN];
  logic [BYTE_W-1:0]   win_nxt [FRAME_LEN];
  logic [FILL_W-1:0]   fill_r;
  logic [FILL_W-1:0]   fill_nxt;
  logic [BODY_LEN-1:0] cols    [BYTE_W];
  logic [BYTE_W-1:0]   body_xor;
  logic                at_last;
  logic                match;

  // shift line, newest byte at the top tap
  always_comb begin
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      win_nxt[i] = win_r[i+1];
    end
    win_nxt[FRAME_LEN-1] = byte_in;
  end

  always_comb begin
    for (int j = 0; j < BYTE_W; j++) begin
      for (int k = 0; k < BODY_LEN; k++) begin
        cols[j][k] = win_nxt[k+1][j];
      end
      body_xor[j] = ^cols[j];
    end
  end

  assign at_last = (fill_r == FILL_W'(FRAME_LEN - 1));
  assign match   = (win_nxt[0] == sync_byte) && (body_xor == win_nxt[FRAME_LEN-1]);

  assign stat.frame_done = byte_valid && at_last;
  assign stat.frame_ok   = match;

  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      words[k] = {win_nxt[1+2*k], win_nxt[2+2*k]};
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (byte_valid) begin
      if (at_last) begin
        // a rejected window keeps all but its oldest byte
        fill_nxt = match ? '0 : fill_r;
      end else begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid) begin
      win_r <= win_nxt;
    end
  end

endmodule

// ----- design/rc_frame_sync_and_channel_store_unit.sv -----
// frame synchronizer and channel store
//
// in_*  : one item per transfer; in_tuser is op (0 = received byte, 1 = channel read),
//         in_tdata carries rx_byte and channel_index
// out_* : one result per frame accepted or per channel read; out_tuser is the
//         result kind, out_tdata the channel value (zero for other kinds)
// cfg_* : writes the sync byte; always ready
//
// a byte that does not complete a valid frame gives no result
// an item waits in the input register and its result in the output register
// throughput: one item per cycle unless the output stalls; the window shift, checksum
// xor tree and sync compare all settle in the cycle between the two registers
// when the receiver stalls the result is held, the input register fills and then
// in_tready drops until the result is taken
// reset: sync byte returns to 0x0F, the window empties and the channel store is
// cleared to zero; there is no clearing pass
module rc_frame_sync_and_channel_store_unit #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rx_byte[7:0], channel_index[12:8], zero pad
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // channel_value[15:0]
  output logic [1:0]  out_tuser,  // result_kind[1:0]
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata   // sync_byte[7:0]
);
  import rcfs_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic                  s1_valid_r;
  logic                  s1_op_r;
  logic [BYTE_W-1:0]     s1_byte_r;
  logic [IDX_W-1:0]      s1_idx_r;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [KIND_W-1:0]     out_kind_r;
  logic [KIND_W-1:0]     out_kind_nxt;
  logic [WORD_W-1:0]     out_value_r;
  logic [WORD_W-1:0]     out_value_nxt;

  logic [BYTE_W-1:0]     sync_r;
  logic [WORD_W-1:0]     tbl_r [NUM_CHANNELS];

  logic                  out_free;
  logic                  s1_go;
  logic                  byte_go;
  logic                  frame_take;
  logic                  idx_ok;
  logic [IDX_W-1:0]      idx_m1;
  rcfs_win_stat_t        win_stat;
  logic [NUM_CHANNELS-1:0][WORD_W-1:0] win_words;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_free;
  assign s1_go     = s1_valid_r && out_free;
  assign byte_go   = s1_go && (s1_op_r == OP_BYTE);
  assign cfg_tready = 1'b1;

  rcfs_window #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_go),
    .byte_in    (s1_byte_r),
    .sync_byte  (sync_r),
    .stat       (win_stat),
    .words      (win_words)
  );

  assign frame_take = win_stat.frame_done && win_stat.frame_ok;
  assign idx_ok     = (s1_idx_r != '0) && (s1_idx_r <= IDX_W'(NUM_CHANNELS));
  assign idx_m1     = s1_idx_r - 1'b1;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    if (s1_go) begin
      if (s1_op_r == OP_READ) begin
        out_valid_nxt = 1'b1;
        if (idx_ok) begin
          out_kind_nxt  = KIND_VALUE;
          out_value_nxt = tbl_r[idx_m1[CH_W-1:0]];
        end else begin
          out_kind_nxt  = KIND_BAD_INDEX;
          out_value_nxt = '0;
        end
      end else if (frame_take) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_FRAME;
        out_value_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sync_r      <= SYNC_RESET;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      out_valid_r <= out_valid_nxt;
      if (cfg_tvalid && cfg_tready) begin
        sync_r <= cfg_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tuser;
      s1_byte_r <= in_tdata[7:0];
      s1_idx_r  <= in_tdata[12:8];
    end
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        tbl_r[k] <= '0;
      end
    end else if (byte_go && frame_take) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        tbl_r[k] <= win_words[k];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_value_r;

endmodule

// ----- design/rcfs_checker.sv -----
module rcfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import rcfs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_FRAME) || (out_tuser == KIND_VALUE) ||
                   (out_tuser == KIND_BAD_INDEX))
    else $error("illegal result kind");

  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_FRAME) |-> out_tdata == '0)
    else $error("frame result carries data");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_BAD_INDEX) |-> out_tdata == '0)
    else $error("bad index result carries data");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind rc_frame_sync_and_channel_store_unit rcfs_checker u_rcfs_checker (.*);
